@@ design/tit_pkg.sv @@
// shared types, constants and the arctangent table for the twist integrator
// no dependencies
package tit_pkg;

  localparam int unsigned Steps = 30;
  localparam int unsigned QuoW = 63;

  localparam logic signed [19:0] PiQ16 = 20'sd205887;
  localparam logic signed [20:0] TwoPiQ16 = 21'sd411775;
  localparam logic signed [20:0] PiPlusTwoPiQ16 = 21'sd617662;
  localparam logic signed [20:0] FourPiQ16 = 21'sd823550;
  localparam logic signed [34:0] PiQ30 = 35'sd3373259426;
  localparam logic signed [34:0] HalfPiQ30 = 35'sd1686629713;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;

  // whole number of turns that keeps the offset turn rate non-negative
  localparam logic [32:0] WrapOffQ16 = 33'd2147818400;
  localparam logic [18:0] TwoPiU = 19'd411775;
  localparam logic [29:0] WrapRecip = 30'((64'd1 << 48) / 64'd411775);

  typedef struct packed {
    logic        zero;
    logic        neg;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [18:0] head;
  } side_t;

  function automatic logic signed [33:0] atan_q30(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned n;
    int unsigned e;
    sum = '0;
    if (i == 0) begin
      return 34'sd843314857;
    end
    for (int unsigned k = 0; k < 31; k++) begin
      n = 2 * k + 1;
      e = i * n;
      if (e <= 60) begin
        term = (64'd1 << (60 - e)) / 64'(n);
        if ((k & 1) == 0) sum = sum + term;
        else sum = sum - term;
      end
    end
    return 34'(signed'((sum + (64'd1 << 29)) >> 30));
  endfunction

endpackage

@@ design/twist_integrate_to_transform.sv @@
// top level of the planar twist integrator: wrap, cordic chain, products, divider chain
// depends on tit_pkg, tit_cordic_cell, tit_div_cell
//
// channel | dir | tdata fields (low bit up)                  | tuser
// in_     | in  | turn_rate[31:0] rate_fwd[63:32] rate_side[95:64] | -
// out_    | out | shift_x[31:0] shift_y[63:32] heading[82:64]   | clipped
//
// one transaction per cycle while out_ is not stalled; 4 + 30 + 2 + 63 + 1 = 100 register stages
// a transaction passes the wrap, cordic, product, divider and output stages in order
// the pipeline is a row of cells; the whole row advances when the output stage can take data
// rst_n clears the valid bits only
// a stall on out_tready holds every stage
module twist_integrate_to_transform import tit_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // turn_rate, rate_fwd, rate_side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // shift_x, shift_y, heading, zero fill
  output logic        out_tuser   // clipped
);

  localparam int unsigned Lat = 4 + Steps + 2 + QuoW + 1;
  localparam int unsigned Pa = 4 + Steps;
  localparam int unsigned Da = Pa + 2;
  localparam int unsigned Oa = Da + QuoW;

  logic           adv;
  logic [Lat-1:0] vld_r;
  logic [Lat-1:0] vld_nxt;

  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign out_tvalid = vld_r[Lat-1];
  assign vld_nxt = {vld_r[Lat-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= vld_nxt;
  end

  // side data travels alongside every stage before the output stage
  side_t side_r [Oa];

  logic signed [31:0] t0_r, t1_r, t2_r, t3_r;
  logic        [32:0] u0_r, u1_r;
  logic        [14:0] q1_r;
  logic        [62:0] qp;
  logic signed [20:0] r2_r;

  // stage 1: quotient estimate by reciprocal
  assign qp = u0_r * WrapRecip;

  // stage 2: remainder, one correction and wrap to (-pi, pi]
  logic        [33:0] qm;
  logic signed [20:0] rm;
  logic signed [20:0] r2_nxt;
  always_comb begin
    qm = q1_r * TwoPiU;
    rm = signed'(21'({1'b0, u1_r} - qm));
    if (rm <= 21'(PiQ16)) r2_nxt = rm;
    else if (rm <= PiPlusTwoPiQ16) r2_nxt = rm - TwoPiQ16;
    else r2_nxt = rm - FourPiQ16;
  end

  // stage 3: quadrant fold
  logic signed [35:0] zs;
  logic signed [35:0] z3_r;
  logic               flip_r [3:Pa-1];
  logic signed [31:0] tp_r [4:Da-1];

  assign zs = 36'(r2_r) <<< 14;

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_r <= in_tdata[31:0];
      u0_r <= 33'(signed'(in_tdata[31:0])) + WrapOffQ16;
      side_r[0] <= {in_tdata[31:0] == 32'd0, in_tdata[31], in_tdata[63:32],
                    in_tdata[95:64], 19'd0};
      t1_r <= t0_r;
      u1_r <= u0_r;
      q1_r <= qp[62:48];
      t2_r <= t1_r;
      r2_r <= r2_nxt;
      t3_r <= t2_r;
      if (zs > 36'(HalfPiQ30)) begin
        z3_r <= zs - 36'(PiQ30);
        flip_r[3] <= 1'b1;
      end else if (zs < -36'(HalfPiQ30)) begin
        z3_r <= zs + 36'(PiQ30);
        flip_r[3] <= 1'b1;
      end else begin
        z3_r <= zs;
        flip_r[3] <= 1'b0;
      end
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
      side_r[3] <= {side_r[2].zero, side_r[2].neg, side_r[2].vx, side_r[2].vy, 19'(r2_r)};
      for (int i = 4; i < Oa; i++) side_r[i] <= side_r[i-1];
      tp_r[4] <= t3_r;
      for (int i = 5; i < Da; i++) tp_r[i] <= tp_r[i-1];
      for (int i = 4; i < Pa; i++) flip_r[i] <= flip_r[i-1];
    end
  end

  // cordic chain
  logic signed [34:0] cx [Steps+1];
  logic signed [34:0] cy [Steps+1];
  logic signed [35:0] cz [Steps+1];
  assign cx[0] = 35'(GainQ30);
  assign cy[0] = '0;
  assign cz[0] = z3_r;

  for (genvar g = 0; g < Steps; g++) begin : g_cordic
    tit_cordic_cell #(.Idx(g)) u_cell (
      .clk(clk), .en(adv),
      .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]),
      .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1])
    );
  end

  // products: sin/omc times rates, then sums
  logic signed [34:0] sn;
  logic signed [35:0] omc;
  assign sn = flip_r[Pa-1] ? -cy[Steps] : cy[Steps];
  assign omc = 36'(OneQ30) - (flip_r[Pa-1] ? -36'(cx[Steps]) : 36'(cx[Steps]));

  logic signed [67:0] p_sx_r, p_ox_r, p_sy_r, p_oy_r;
  logic signed [69:0] nx_r, ny_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_sx_r <= 68'(sn) * 68'(signed'(side_r[Pa-1].vx));
      p_sy_r <= 68'(sn) * 68'(signed'(side_r[Pa-1].vy));
      p_ox_r <= 68'(omc) * 68'(signed'(side_r[Pa-1].vx));
      p_oy_r <= 68'(omc) * 68'(signed'(side_r[Pa-1].vy));
      nx_r <= 70'(p_sx_r) - 70'(p_oy_r);
      ny_r <= 70'(p_ox_r) + 70'(p_sy_r);
    end
  end

  // sign handling and rounding bias: q = (|n| + d/2) / d
  logic [69:0] ax, ay;
  logic        sgx, sgy;
  logic [45:0] den;
  logic [31:0] tabs;
  always_comb begin
    sgx = nx_r[69] ^ side_r[Da-1].neg;
    sgy = ny_r[69] ^ side_r[Da-1].neg;
    ax = nx_r[69] ? -nx_r : nx_r;
    ay = ny_r[69] ? -ny_r : ny_r;
    tabs = tp_r[Da-1][31] ? -tp_r[Da-1] : tp_r[Da-1];
    den = {tabs, 14'd0};
  end

  logic [QuoW-1:0] nxb, nyb;
  assign nxb = QuoW'(ax + 70'(den >> 1));
  assign nyb = QuoW'(ay + 70'(den >> 1));

  logic [QuoW-1:0] rx [QuoW+1];
  logic [QuoW-1:0] nxs [QuoW+1];
  logic [QuoW-1:0] qx [QuoW+1];
  logic [45:0]     dxs [QuoW+1];
  logic [QuoW-1:0] ry [QuoW+1];
  logic [QuoW-1:0] nys [QuoW+1];
  logic [QuoW-1:0] qy [QuoW+1];
  logic [45:0]     dys [QuoW+1];
  logic            sg_r [QuoW+1][2];

  assign rx[0] = '0;
  assign nxs[0] = nxb;
  assign qx[0] = '0;
  assign dxs[0] = den;
  assign ry[0] = '0;
  assign nys[0] = nyb;
  assign qy[0] = '0;
  assign dys[0] = den;
  assign sg_r[0][0] = sgx;
  assign sg_r[0][1] = sgy;

  for (genvar g = 0; g < QuoW; g++) begin : g_div
    tit_div_cell u_dx (
      .clk(clk), .en(adv),
      .rem_i(rx[g]), .num_i(nxs[g]), .quo_i(qx[g]), .den_i(dxs[g]),
      .rem_o(rx[g+1]), .num_o(nxs[g+1]), .quo_o(qx[g+1]), .den_o(dxs[g+1])
    );
    tit_div_cell u_dy (
      .clk(clk), .en(adv),
      .rem_i(ry[g]), .num_i(nys[g]), .quo_i(qy[g]), .den_i(dys[g]),
      .rem_o(ry[g+1]), .num_o(nys[g+1]), .quo_o(qy[g+1]), .den_o(dys[g+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sg_r[g+1][0] <= sg_r[g][0];
        sg_r[g+1][1] <= sg_r[g][1];
      end
    end
  end

  // output stage: sign, saturate, and pass the rates through for a zero turn rate
  logic signed [QuoW:0] sqx, sqy;
  logic [31:0] ox, oy;
  logic        cxf, cyf;
  always_comb begin
    sqx = sg_r[QuoW][0] ? -$signed({1'b0, qx[QuoW]}) : $signed({1'b0, qx[QuoW]});
    sqy = sg_r[QuoW][1] ? -$signed({1'b0, qy[QuoW]}) : $signed({1'b0, qy[QuoW]});
    cxf = 1'b0;
    cyf = 1'b0;
    ox = 32'(sqx);
    oy = 32'(sqy);
    if (sqx > 64'sd2147483647) begin
      ox = 32'h7fffffff; cxf = 1'b1;
    end else if (sqx < -64'sd2147483648) begin
      ox = 32'h80000000; cxf = 1'b1;
    end
    if (sqy > 64'sd2147483647) begin
      oy = 32'h7fffffff; cyf = 1'b1;
    end else if (sqy < -64'sd2147483648) begin
      oy = 32'h80000000; cyf = 1'b1;
    end
    if (side_r[Oa-1].zero) begin
      ox = side_r[Oa-1].vx;
      oy = side_r[Oa-1].vy;
      cxf = 1'b0;
      cyf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata <= {5'd0, side_r[Oa-1].head, oy, ox};
      out_tuser <= cxf | cyf;
    end
  end

endmodule

@@ design/tit_cordic_cell.sv @@
// one registered rotation step of the sine/cosine chain
// depends on tit_pkg
module tit_cordic_cell import tit_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [34:0] x_i,
  input  logic signed [34:0] y_i,
  input  logic signed [35:0] z_i,
  output logic signed [34:0] x_o,
  output logic signed [34:0] y_o,
  output logic signed [35:0] z_o
);

  localparam logic signed [35:0] Ang = 36'(atan_q30(Idx));

  logic signed [34:0] dx;
  logic signed [34:0] dy;

  assign dx = x_i >>> Idx;
  assign dy = y_i >>> Idx;

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_i >= 0) begin
        x_o <= x_i - dy;
        y_o <= y_i + dx;
        z_o <= z_i - Ang;
      end else begin
        x_o <= x_i + dy;
        y_o <= y_i - dx;
        z_o <= z_i + Ang;
      end
    end
  end

endmodule

@@ design/tit_div_cell.sv @@
// one registered restoring-division step, one quotient bit per cell
// depends on tit_pkg
module tit_div_cell import tit_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [QuoW-1:0]   rem_i,
  input  logic [QuoW-1:0]   num_i,
  input  logic [QuoW-1:0]   quo_i,
  input  logic [45:0]       den_i,
  output logic [QuoW-1:0]   rem_o,
  output logic [QuoW-1:0]   num_o,
  output logic [QuoW-1:0]   quo_o,
  output logic [45:0]       den_o
);

  logic [QuoW:0] trial;

  assign trial = {rem_i, num_i[QuoW-1]};

  always_ff @(posedge clk) begin
    if (en) begin
      den_o <= den_i;
      num_o <= num_i << 1;
      if (trial >= {{(QuoW - 45){1'b0}}, den_i}) begin
        rem_o <= QuoW'(trial - {{(QuoW - 45){1'b0}}, den_i});
        quo_o <= {quo_i[QuoW-2:0], 1'b1};
      end else begin
        rem_o <= QuoW'(trial);
        quo_o <= {quo_i[QuoW-2:0], 1'b0};
      end
    end
  end

endmodule
